>>> rtl/core/pca_pkg.sv
// shared types, codes and helpers for the pixel colour adjust block
`timescale 1ns / 1ps

package pca_pkg;

  typedef enum logic [1:0] {
    MODE_CONTRAST   = 2'd0,
    MODE_SATURATION = 2'd1,
    MODE_LIGHTNESS  = 2'd2,
    MODE_BYPASS     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [8:0]        gain;
    logic signed [8:0] offset;
  } pca_cfg_t;

  typedef struct packed {
    logic load2;
    logic load3;
  } pca_ctl_t;

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/pca_chan.sv
// one colour channel: saturation product, scaling, offset, clamp, curve pass and bypass
`timescale 1ns / 1ps

module pca_chan
  import pca_pkg::*;
(
  input  logic       clk,
  input  pca_ctl_t   ctl,
  input  pca_cfg_t   cfg,
  input  logic [7:0] chan,
  input  logic [9:0] sum,
  input  logic [7:0] curve,
  output logic [7:0] result
);

  localparam logic signed [12:0] DIV_BIAS   = 13'sd1530;
  localparam logic signed [11:0] QUOT_BIAS  = 12'sd510;
  localparam logic [11:0]        RECIP3     = 12'd2731;
  localparam int                 RECIP_SHIFT = 13;

  logic [9:0]          chan3;
  logic signed [10:0]  diff;
  logic signed [20:0]  prod_full;

  logic [7:0]          c2;
  logic [7:0]          curve2;
  logic signed [19:0]  prod2;

  logic signed [11:0]  q;
  logic signed [12:0]  biased;
  logic [11:0]         u;
  logic [23:0]         quot;
  logic signed [11:0]  d;
  logic signed [11:0]  sat_sum;
  logic signed [11:0]  light_sum;
  logic [7:0]          result_next;

  assign chan3     = {2'b00, chan} + {1'b0, chan, 1'b0};
  assign diff      = $signed({1'b0, chan3}) - $signed({1'b0, sum});
  assign prod_full = diff * $signed({1'b0, cfg.gain});

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      c2     <= chan;
      curve2 <= curve;
      prod2  <= prod_full[19:0];
    end
  end

  // floor by 768: arithmetic shift right by 8 (floor by 256), then floor by 3 via reciprocal
  assign q         = prod2[19:8];
  assign biased    = {q[11], q} + DIV_BIAS;
  assign u         = biased[11:0];
  assign quot      = u * RECIP3;
  assign d         = $signed({2'b00, quot[RECIP_SHIFT+9:RECIP_SHIFT]}) - QUOT_BIAS;
  assign sat_sum   = $signed({4'b0000, c2}) + d;
  assign light_sum = $signed({4'b0000, c2}) + {{3{cfg.offset[8]}}, cfg.offset};

  always_comb begin
    case (cfg.mode)
      MODE_CONTRAST:   result_next = curve2;
      MODE_SATURATION: result_next = clamp_byte(sat_sum);
      MODE_LIGHTNESS:  result_next = clamp_byte(light_sum);
      default:         result_next = c2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/core/pixel_color_adjust.sv
// Pixel colour adjust block.
// Input channel (in_valid/in_ready) carries one item per handshake: either a
// BGR pixel (command 0) or a write of one contrast curve entry (command 1).
// Output channel (out_valid/out_ready) returns one adjusted pixel for each
// pixel item, in order; table writes give no output.
// Mode, saturation gain and lightness offset sit behind an APB-style port at
// byte addresses 0, 4 and 8; change them only while the block is idle.
// A pixel is registered in turn at input and curve read, product and result.
// Throughput: one item per cycle while out_ready holds, set by a three stage
// pipeline with two multipliers per channel and two curve memories (blue and
// green share one dual read port memory, red has its own copy).
// A table write lands in both memories at its accept edge, so a pixel right
// behind it already sees the new entry.
// Reset clears the pipeline and the registers; curve entries read before they
// are written give undefined values.
// When out_ready is low the pipeline holds; bubbles close up, and in_ready
// falls once all three stages hold a pixel.
`timescale 1ns / 1ps

module pixel_color_adjust
  import pca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  red_in,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out
);

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic       CMD_PIXEL  = 1'b0;
  localparam logic       CMD_TABLE  = 1'b1;

  pca_cfg_t   cfg;
  pca_ctl_t   ctl;
  logic       cfg_wr;

  logic [7:0] mem_bg [256];
  logic [7:0] mem_r  [256];

  logic       v1;
  logic       v2;
  logic [7:0] b1;
  logic [7:0] g1;
  logic [7:0] r1;
  logic [7:0] tb1;
  logic [7:0] tg1;
  logic [7:0] tr1;
  logic [9:0] sum1;

  logic       rdy2;
  logic       adv3;
  logic       pix_acc;
  logic       tab_acc;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_CONTRAST;
      cfg.gain   <= 9'd0;
      cfg.offset <= 9'sd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:   cfg.mode   <= mode_t'(pwdata[1:0]);
        REG_GAIN:   cfg.gain   <= pwdata[8:0];
        REG_OFFSET: cfg.offset <= $signed(pwdata[8:0]);
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, cfg.mode};
      REG_GAIN:   prdata = {23'd0, cfg.gain};
      REG_OFFSET: prdata = {23'd0, cfg.offset};
      default:    prdata = 32'd0;
    endcase
  end

  // pipeline control
  assign adv3     = !out_valid || out_ready;
  assign rdy2     = !v2 || adv3;
  assign in_ready = !v1 || rdy2;
  assign pix_acc  = in_valid && in_ready && (command == CMD_PIXEL);
  assign tab_acc  = in_valid && in_ready && (command == CMD_TABLE);
  assign ctl.load2 = rdy2 && v1;
  assign ctl.load3 = adv3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= pix_acc;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (adv3) begin
        out_valid <= v2;
      end
    end
  end

  // curve memories
  always_ff @(posedge clk) begin
    if (tab_acc) begin
      mem_bg[entry_index] <= entry_value;
    end
    if (pix_acc) begin
      tb1 <= mem_bg[blue_in];
      tg1 <= mem_bg[green_in];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_acc) begin
      mem_r[entry_index] <= entry_value;
    end
    if (pix_acc) begin
      tr1 <= mem_r[red_in];
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      b1 <= blue_in;
      g1 <= green_in;
      r1 <= red_in;
    end
  end

  assign sum1 = {2'b00, b1} + {2'b00, g1} + {2'b00, r1};

  pca_chan u_blue (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg),
    .chan   (b1),
    .sum    (sum1),
    .curve  (tb1),
    .result (blue_out)
  );

  pca_chan u_green (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg),
    .chan   (g1),
    .sum    (sum1),
    .curve  (tg1),
    .result (green_out)
  );

  pca_chan u_red (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg),
    .chan   (r1),
    .sum    (sum1),
    .curve  (tr1),
    .result (red_out)
  );

  a_table_no_item : assert property (@(posedge clk) disable iff (rst)
    tab_acc |=> !v1)
    else $error("table write entered the pixel pipeline");

  a_pixel_enters : assert property (@(posedge clk) disable iff (rst)
    pix_acc |=> v1)
    else $error("accepted pixel lost at first stage");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted into a full stalled pipeline");

  a_stage2_hold : assert property (@(posedge clk) disable iff (rst)
    (v2 && out_valid && !out_ready) |=> v2)
    else $error("stalled pixel dropped from second stage");

endmodule
